[rtl/core/cpl_pkg.sv]
// Shared constants, register indexes and sideband types for the chassis current
// power limiter. Used by all modules but cpl_div; depends on nothing.
`default_nettype none

package cpl_pkg;

   localparam int MOTOR_COUNT = 4;
   localparam int CUR_W       = 16;
   localparam int MAG_W       = 16;
   localparam int SUM_W       = MAG_W + $clog2(MOTOR_COUNT);
   localparam int LIMIT_W     = 17;
   localparam int FRAC_W      = 16;
   localparam int POWER_W     = 16;
   localparam int BUF_W       = 9;

   localparam logic [LIMIT_W-1:0] LIMIT_MAX = {LIMIT_W{1'b1}};

   // front dividers: share fraction, buffer fraction and taper fraction
   localparam int FDIV_NUM_W = 30;
   localparam int FDIV_DEN_W = 13;
   // back divider: limit over current sum
   localparam int LDIV_NUM_W = LIMIT_W + FRAC_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_POWER_LIMIT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WARN_BUFFER   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_BUFFER    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_LIMIT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_POWER_BASE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_POWER     = 3'd5;

   localparam logic [7:0]  RST_POWER_LIMIT  = 8'd80;
   localparam logic [7:0]  RST_WARN_BUFFER  = 8'd50;
   localparam logic [7:0]  RST_MIN_BUFFER   = 8'd5;
   localparam logic [15:0] RST_BUFFER_LIMIT = 16'd16000;
   localparam logic [15:0] RST_POWER_BASE   = 16'd20000;
   localparam logic [7:0]  RST_REF_POWER    = 8'd80;

   typedef struct packed {
      logic                              p_eq_r;
      logic                              hi_power;
      logic [MOTOR_COUNT-1:0]            neg;
      logic [MOTOR_COUNT-1:0][MAG_W-1:0] mag;
      logic [SUM_W-1:0]                  total;
   } front_sb_type;

   typedef struct packed {
      logic [LIMIT_W-1:0]                limit;
      logic                              scaled;
      logic [MOTOR_COUNT-1:0]            neg;
      logic [MOTOR_COUNT-1:0][MAG_W-1:0] mag;
   } back_sb_type;

endpackage

`default_nettype wire

[rtl/core/cpl_div.sv]
// Pipelined restoring divider, one quotient bit per register stage, with sideband.
// Depends on nothing; widths come from its parameters.
`default_nettype none

module cpl_div #(
   parameter int NUM_W = 30,
   parameter int DEN_W = 13,
   parameter int SB_W  = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire logic [NUM_W-1:0] in_num,
   input  wire logic [DEN_W-1:0] in_den,
   input  wire logic [SB_W-1:0]  in_sb,
   output logic                  out_valid,
   output logic [NUM_W-1:0]      out_quot,
   output logic [SB_W-1:0]       out_sb
);

   logic             vld_ff  [NUM_W];
   logic [DEN_W-1:0] rem_ff  [NUM_W];
   logic [NUM_W-1:0] numq_ff [NUM_W];
   logic [DEN_W-1:0] den_ff  [NUM_W];
   logic [SB_W-1:0]  sb_ff   [NUM_W];

   genvar s;
   generate
      for (s = 0; s < NUM_W; s++) begin : g_step
         logic             vld_prev;
         logic [DEN_W-1:0] rem_prev;
         logic [NUM_W-1:0] numq_prev;
         logic [DEN_W-1:0] den_prev;
         logic [SB_W-1:0]  sb_prev;
         logic [DEN_W:0]   trial;
         logic [DEN_W:0]   diff;
         logic             ge;
         logic [DEN_W-1:0] rem_in;
         logic [NUM_W-1:0] numq_in;

         if (s == 0) begin : g_first
            assign vld_prev  = in_valid;
            assign rem_prev  = '0;
            assign numq_prev = in_num;
            assign den_prev  = in_den;
            assign sb_prev   = in_sb;
         end else begin : g_next
            assign vld_prev  = vld_ff[s-1];
            assign rem_prev  = rem_ff[s-1];
            assign numq_prev = numq_ff[s-1];
            assign den_prev  = den_ff[s-1];
            assign sb_prev   = sb_ff[s-1];
         end

         // shift in the next dividend bit, subtract when it fits
         always_comb begin
            trial   = {rem_prev, numq_prev[NUM_W-1]};
            diff    = trial - {1'b0, den_prev};
            ge      = (trial >= {1'b0, den_prev});
            rem_in  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            numq_in = {numq_prev[NUM_W-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[s] <= 1'b0;
            end else if (en) begin
               vld_ff[s] <= vld_prev;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s]  <= rem_in;
               numq_ff[s] <= numq_in;
               den_ff[s]  <= den_prev;
               sb_ff[s]   <= sb_prev;
            end
         end
      end
   endgenerate

   assign out_valid = vld_ff[NUM_W-1];
   assign out_quot  = numq_ff[NUM_W-1];
   assign out_sb    = sb_ff[NUM_W-1];

endmodule

`default_nettype wire

[rtl/core/cpl_limit.sv]
// Three-stage limit path: share and buffer products, taper product, then select
// and saturate. Depends on cpl_pkg.
`default_nettype none

module cpl_limit
   import cpl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire logic [FDIV_NUM_W-1:0] in_frac_share,
   input  wire logic [FDIV_NUM_W-1:0] in_frac_buf,
   input  wire logic [FDIV_NUM_W-1:0] in_frac_taper,
   input  wire logic                  in_low_buf,
   input  wire logic                  in_taper_ok,
   input  wire front_sb_type          in_sb,
   input  wire logic [15:0]           cfg_buffer_limit,
   input  wire logic [15:0]           cfg_power_base,
   output logic                       out_valid,
   output logic [LDIV_NUM_W-1:0]      out_num,
   output logic [SUM_W-1:0]           out_den,
   output back_sb_type                out_sb
);

   localparam int FS_W    = 24;
   localparam int FB_W    = 25;
   localparam int FT_W    = 18;
   localparam int SHARE_W = 24;
   localparam int LBL_W   = 25;
   localparam int SF_W    = 26;
   localparam int WIDE_W  = 27;
   localparam int CMP_W   = LIMIT_W + SUM_W;

   // stage 1
   logic                  v1_ff;
   logic [SHARE_W-1:0]    share1_ff;
   logic [SHARE_W-1:0]    share1_in;
   logic [LBL_W-1:0]      lbl1_ff;
   logic [FT_W-1:0]       ft1_ff;
   logic                  lb1_ff;
   logic                  tok1_ff;
   front_sb_type          sb1_ff;
   logic [16+FS_W-1:0]    share_prod;
   logic [16+FB_W-1:0]    lbl_prod;

   // stage 2
   logic                  v2_ff;
   logic [SHARE_W-1:0]    share2_ff;
   logic [LBL_W-1:0]      lbl2_ff;
   logic [SF_W-1:0]       sf2_ff;
   logic                  lb2_ff;
   logic                  tok2_ff;
   front_sb_type          sb2_ff;
   logic [SHARE_W+FT_W-1:0] sf_prod;

   // stage 3
   logic                  v3_ff;
   logic [LIMIT_W-1:0]    limit_ff;
   logic [LIMIT_W-1:0]    limit_in;
   logic                  scaled_ff;
   logic                  scaled_in;
   front_sb_type          sb3_ff;
   logic [WIDE_W-1:0]     wide;

   always_comb begin
      share_prod = 40'(cfg_power_base) * 40'(in_frac_share[FS_W-1:0]);
      lbl_prod   = 41'(cfg_buffer_limit) * 41'(in_frac_buf[FB_W-1:0]);
      share1_in  = in_sb.p_eq_r ? SHARE_W'(cfg_power_base)
                                : share_prod[16+FS_W-1:FRAC_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         share1_ff <= share1_in;
         lbl1_ff   <= lbl_prod[16+FB_W-1:FRAC_W];
         ft1_ff    <= in_frac_taper[FT_W-1:0];
         lb1_ff    <= in_low_buf;
         tok1_ff   <= in_taper_ok;
         sb1_ff    <= in_sb;
      end
   end

   assign sf_prod = 42'(share1_ff) * 42'(ft1_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         share2_ff <= share1_ff;
         lbl2_ff   <= lbl1_ff;
         sf2_ff    <= sf_prod[SHARE_W+FT_W-1:FRAC_W];
         lb2_ff    <= lb1_ff;
         tok2_ff   <= tok1_ff;
         sb2_ff    <= sb1_ff;
      end
   end

   // low buffer wins; otherwise taper above the threshold power
   always_comb begin
      priority if (lb2_ff) begin
         wide = WIDE_W'(lbl2_ff);
      end else if (sb2_ff.hi_power) begin
         wide = WIDE_W'(cfg_buffer_limit) + (tok2_ff ? WIDE_W'(sf2_ff) : '0);
      end else begin
         wide = WIDE_W'(cfg_buffer_limit) + WIDE_W'(share2_ff);
      end
      limit_in  = (wide > WIDE_W'(LIMIT_MAX)) ? LIMIT_MAX : wide[LIMIT_W-1:0];
      scaled_in = CMP_W'(sb2_ff.total) > CMP_W'(limit_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         limit_ff  <= limit_in;
         scaled_ff <= scaled_in;
         sb3_ff    <= sb2_ff;
      end
   end

   assign out_valid     = v3_ff;
   assign out_num       = {limit_ff, {FRAC_W{1'b0}}};
   assign out_den       = sb3_ff.total;
   assign out_sb.limit  = limit_ff;
   assign out_sb.scaled = scaled_ff;
   assign out_sb.neg    = sb3_ff.neg;
   assign out_sb.mag    = sb3_ff.mag;

endmodule

`default_nettype wire

[rtl/core/cpl_scale.sv]
// Final stage: scales each current magnitude by the limit ratio when the sum is over
// the limit, and restores sign. Depends on cpl_pkg.
`default_nettype none

module cpl_scale
   import cpl_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire logic [LDIV_NUM_W-1:0]     in_quot,
   input  wire back_sb_type               in_sb,
   output logic                           out_valid,
   output logic [MOTOR_COUNT-1:0][CUR_W-1:0] out_current,
   output logic [LIMIT_W-1:0]             out_limit,
   output logic                           out_scaled
);

   logic                             v_ff;
   logic [MOTOR_COUNT-1:0][CUR_W-1:0] cur_ff;
   logic [MOTOR_COUNT-1:0][CUR_W-1:0] cur_in;
   logic [LIMIT_W-1:0]               limit_ff;
   logic                             scaled_ff;

   always_comb begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
         logic [MAG_W+FRAC_W-1:0] prod;
         logic [MAG_W-1:0]        a;
         prod = (MAG_W+FRAC_W)'(in_sb.mag[i]) * (MAG_W+FRAC_W)'(in_quot[FRAC_W-1:0]);
         a    = in_sb.scaled ? prod[MAG_W+FRAC_W-1:FRAC_W] : in_sb.mag[i];
         cur_in[i] = in_sb.neg[i] ? CUR_W'(0 - a) : CUR_W'(a);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cur_ff    <= cur_in;
         limit_ff  <= in_sb.limit;
         scaled_ff <= in_sb.scaled;
      end
   end

   assign out_valid   = v_ff;
   assign out_current = cur_ff;
   assign out_limit   = limit_ff;
   assign out_scaled  = scaled_ff;

endmodule

`default_nettype wire

[rtl/core/chassis_motor_current_power_limiter.sv]
// Chassis motor current power limiter: top level with register file, input stage,
// dividers, limit path, scaling stage and output register. Depends on cpl_pkg.
`default_nettype none

// Takes one transaction per clock while req_ready is high and returns one result
// per transaction, in order. A transaction passes the input stage, the front
// dividers (30 stages for the share, buffer and taper fractions), three limit
// stages, the ratio divider (33 stages for the limit-over-sum ratio), the scaling
// stage and the output register. The output register lets a new transaction
// enter while a finished result waits; a stall only holds the pipeline once a
// finished result sits behind the waiting one. The user must write registers
// through csr_* only while the block is idle; the block does not enforce this.
module chassis_motor_current_power_limiter
   import cpl_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [POWER_W-1:0]      req_measured_power,
   input  wire logic [BUF_W-1:0]        req_buffer_energy,
   input  wire logic signed [CUR_W-1:0] req_motor_current_0,
   input  wire logic signed [CUR_W-1:0] req_motor_current_1,
   input  wire logic signed [CUR_W-1:0] req_motor_current_2,
   input  wire logic signed [CUR_W-1:0] req_motor_current_3,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [CUR_W-1:0]      rsp_limited_current_0,
   output logic signed [CUR_W-1:0]      rsp_limited_current_1,
   output logic signed [CUR_W-1:0]      rsp_limited_current_2,
   output logic signed [CUR_W-1:0]      rsp_limited_current_3,
   output logic [LIMIT_W-1:0]           rsp_total_limit,
   output logic                         rsp_was_scaled,
   input  wire logic                    csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_write_data
);

   // configuration registers
   logic [7:0]  power_limit_ff;
   logic [7:0]  warn_buffer_ff;
   logic [7:0]  min_buffer_ff;
   logic [15:0] buffer_limit_ff;
   logic [15:0] power_base_ff;
   logic [7:0]  ref_power_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         power_limit_ff  <= RST_POWER_LIMIT;
         warn_buffer_ff  <= RST_WARN_BUFFER;
         min_buffer_ff   <= RST_MIN_BUFFER;
         buffer_limit_ff <= RST_BUFFER_LIMIT;
         power_base_ff   <= RST_POWER_BASE;
         ref_power_ff    <= RST_REF_POWER;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_POWER_LIMIT:  power_limit_ff  <= csr_write_data[7:0];
            CSR_WARN_BUFFER:  warn_buffer_ff  <= csr_write_data[7:0];
            CSR_MIN_BUFFER:   min_buffer_ff   <= csr_write_data[7:0];
            CSR_BUFFER_LIMIT: buffer_limit_ff <= csr_write_data;
            CSR_POWER_BASE:   power_base_ff   <= csr_write_data;
            CSR_REF_POWER:    ref_power_ff    <= csr_write_data[7:0];
            default: begin
            end
         endcase
      end
   end

   logic pipe_en;
   logic out_en;

   // input stage
   logic [7:0]                r_eff;
   logic [7:0]                d_pow;
   logic [BUF_W-1:0]          e_buf;
   logic [POWER_W-1:0]        taper_diff;
   logic [MOTOR_COUNT-1:0][CUR_W-1:0] cur_arr;
   front_sb_type              sb0_in;

   logic                      s0_vld_ff;
   logic [FDIV_NUM_W-1:0]     num1_ff, num2_ff, num3_ff;
   logic [FDIV_DEN_W-1:0]     den1_ff, den2_ff, den3_ff;
   logic                      low_buf_ff;
   logic                      taper_ok_ff;
   front_sb_type              sb0_ff;

   assign cur_arr = {req_motor_current_3, req_motor_current_2,
                     req_motor_current_1, req_motor_current_0};

   always_comb begin
      r_eff = (ref_power_ff == 8'd0) ? 8'd1 : ref_power_ff;
      d_pow = (power_limit_ff >= r_eff) ? (power_limit_ff - r_eff)
                                        : (r_eff - power_limit_ff);
      e_buf = (req_buffer_energy > BUF_W'(min_buffer_ff)) ? req_buffer_energy
                                                          : BUF_W'(min_buffer_ff);
      taper_diff = {2'b00, power_limit_ff, 6'b0} - req_measured_power;
      sb0_in.p_eq_r   = (power_limit_ff == r_eff);
      sb0_in.hi_power = (req_measured_power > {2'b00, warn_buffer_ff, 6'b0});
      sb0_in.total    = '0;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
         sb0_in.neg[i] = cur_arr[i][CUR_W-1];
         sb0_in.mag[i] = cur_arr[i][CUR_W-1] ? MAG_W'(0 - cur_arr[i]) : MAG_W'(cur_arr[i]);
         sb0_in.total  = sb0_in.total + SUM_W'(sb0_in.mag[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         s0_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         num1_ff     <= FDIV_NUM_W'({d_pow, {FRAC_W{1'b0}}});
         den1_ff     <= FDIV_DEN_W'(r_eff);
         num2_ff     <= FDIV_NUM_W'({e_buf, {FRAC_W{1'b0}}});
         den2_ff     <= FDIV_DEN_W'(warn_buffer_ff);
         num3_ff     <= {taper_diff[13:0], {FRAC_W{1'b0}}};
         den3_ff     <= {power_limit_ff, 5'b0};
         low_buf_ff  <= (req_buffer_energy < BUF_W'(warn_buffer_ff));
         taper_ok_ff <= (req_measured_power < {2'b00, power_limit_ff, 6'b0});
         sb0_ff      <= sb0_in;
      end
   end

   // front dividers
   logic                  fd1_valid, fd2_valid, fd3_valid;
   logic [FDIV_NUM_W-1:0] frac_share, frac_buf, frac_taper;
   logic [$bits(front_sb_type)-1:0] fd1_sb;
   logic                  fd2_low_buf, fd3_taper_ok;

   cpl_div #(.NUM_W(FDIV_NUM_W), .DEN_W(FDIV_DEN_W), .SB_W($bits(front_sb_type)))
   u_div_share (
      .clock(clock), .reset(reset), .en(pipe_en),
      .in_valid(s0_vld_ff), .in_num(num1_ff), .in_den(den1_ff), .in_sb(sb0_ff),
      .out_valid(fd1_valid), .out_quot(frac_share), .out_sb(fd1_sb)
   );

   cpl_div #(.NUM_W(FDIV_NUM_W), .DEN_W(FDIV_DEN_W), .SB_W(1))
   u_div_buf (
      .clock(clock), .reset(reset), .en(pipe_en),
      .in_valid(s0_vld_ff), .in_num(num2_ff), .in_den(den2_ff), .in_sb(low_buf_ff),
      .out_valid(fd2_valid), .out_quot(frac_buf), .out_sb(fd2_low_buf)
   );

   cpl_div #(.NUM_W(FDIV_NUM_W), .DEN_W(FDIV_DEN_W), .SB_W(1))
   u_div_taper (
      .clock(clock), .reset(reset), .en(pipe_en),
      .in_valid(s0_vld_ff), .in_num(num3_ff), .in_den(den3_ff), .in_sb(taper_ok_ff),
      .out_valid(fd3_valid), .out_quot(frac_taper), .out_sb(fd3_taper_ok)
   );

   // limit path
   logic                  lim_valid;
   logic [LDIV_NUM_W-1:0] lim_num;
   logic [SUM_W-1:0]      lim_den;
   back_sb_type           lim_sb;

   cpl_limit u_limit (
      .clock(clock), .reset(reset), .en(pipe_en),
      .in_valid(fd1_valid & fd2_valid & fd3_valid),
      .in_frac_share(frac_share), .in_frac_buf(frac_buf), .in_frac_taper(frac_taper),
      .in_low_buf(fd2_low_buf), .in_taper_ok(fd3_taper_ok),
      .in_sb(front_sb_type'(fd1_sb)),
      .cfg_buffer_limit(buffer_limit_ff), .cfg_power_base(power_base_ff),
      .out_valid(lim_valid), .out_num(lim_num), .out_den(lim_den), .out_sb(lim_sb)
   );

   // ratio divider
   logic                  ld_valid;
   logic [LDIV_NUM_W-1:0] ld_quot;
   logic [$bits(back_sb_type)-1:0] ld_sb_raw;
   back_sb_type           ld_sb;

   cpl_div #(.NUM_W(LDIV_NUM_W), .DEN_W(SUM_W), .SB_W($bits(back_sb_type)))
   u_div_ratio (
      .clock(clock), .reset(reset), .en(pipe_en),
      .in_valid(lim_valid), .in_num(lim_num), .in_den(lim_den), .in_sb(lim_sb),
      .out_valid(ld_valid), .out_quot(ld_quot), .out_sb(ld_sb_raw)
   );

   assign ld_sb = back_sb_type'(ld_sb_raw);

   // scaling stage
   logic                             sc_valid;
   logic [MOTOR_COUNT-1:0][CUR_W-1:0] sc_current;
   logic [LIMIT_W-1:0]               sc_limit;
   logic                             sc_scaled;

   cpl_scale u_scale (
      .clock(clock), .reset(reset), .en(pipe_en),
      .in_valid(ld_valid), .in_quot(ld_quot), .in_sb(ld_sb),
      .out_valid(sc_valid), .out_current(sc_current),
      .out_limit(sc_limit), .out_scaled(sc_scaled)
   );

   // output register; hold the pipeline only when a result waits behind it
   logic                             rsp_valid_ff;
   logic [MOTOR_COUNT-1:0][CUR_W-1:0] rsp_cur_ff;
   logic [LIMIT_W-1:0]               rsp_limit_ff;
   logic                             rsp_scaled_ff;

   assign out_en    = !rsp_valid_ff || rsp_ready;
   assign pipe_en   = !sc_valid || out_en;
   assign req_ready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= sc_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && sc_valid) begin
         rsp_cur_ff    <= sc_current;
         rsp_limit_ff  <= sc_limit;
         rsp_scaled_ff <= sc_scaled;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_limited_current_0 = rsp_cur_ff[0];
   assign rsp_limited_current_1 = rsp_cur_ff[1];
   assign rsp_limited_current_2 = rsp_cur_ff[2];
   assign rsp_limited_current_3 = rsp_cur_ff[3];
   assign rsp_total_limit       = rsp_limit_ff;
   assign rsp_was_scaled        = rsp_scaled_ff;

   // front dividers must stay in lockstep
   a_front_lockstep: assert property (@(posedge clock) disable iff (reset)
      (fd1_valid == fd2_valid) && (fd2_valid == fd3_valid))
      else $error("front divider valids diverged");

   // a scaled transaction always has a ratio below one
   a_ratio_below_one: assert property (@(posedge clock) disable iff (reset)
      ld_valid && ld_sb.scaled |-> ld_quot[LDIV_NUM_W-1:FRAC_W] == '0)
      else $error("scaling ratio not below one");

   // an accepted transaction enters the input stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s0_vld_ff)
      else $error("accepted transaction lost at input stage");

   // a new result only comes from a valid scaling stage
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(sc_valid))
      else $error("result appeared without a source");

endmodule

`default_nettype wire

[tb/sv/chassis_motor_current_power_limiter_tb.sv]
// Testbench for the chassis motor current power limiter: directed and random
// transactions checked against a behavioural limit and scaling predictor.
// Depends on cpl_pkg and the chassis_motor_current_power_limiter RTL.
`timescale 1ns / 1ps

module chassis_motor_current_power_limiter_tb;
   import cpl_pkg::*;

   typedef struct packed {
      logic [15:0] c0, c1, c2, c3;
      logic [16:0] lim;
      logic        scaled;
   } limit_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [POWER_W-1:0] req_measured_power = '0;
   logic [BUF_W-1:0] req_buffer_energy = '0;
   logic signed [CUR_W-1:0] req_motor_current_0 = '0, req_motor_current_1 = '0;
   logic signed [CUR_W-1:0] req_motor_current_2 = '0, req_motor_current_3 = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [CUR_W-1:0] rsp_limited_current_0, rsp_limited_current_1;
   logic signed [CUR_W-1:0] rsp_limited_current_2, rsp_limited_current_3;
   logic [LIMIT_W-1:0] rsp_total_limit;
   logic rsp_was_scaled;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   chassis_motor_current_power_limiter u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the limiter settings
   logic [7:0]  cfg_power_limit, cfg_warn_buffer, cfg_min_buffer, cfg_ref_power;
   logic [15:0] cfg_buffer_limit, cfg_power_base;

   limit_result_type expected_results[$];
   int  error_count = 0;
   int  result_count = 0;
   int  scaled_count = 0;
   bit  idle_enable = 1'b1;

   function automatic logic [63:0] fraction16(logic [63:0] num, logic [63:0] den);
      if (den == 0) return 0;
      return (num << 16) / den;
   endfunction

   function automatic limit_result_type predict_limit(logic [15:0] power, logic [8:0] energy,
                                                      logic [63:0] cur);
      logic [63:0] p, w, r, share, lim, total, q, e, f, d, a;
      logic [63:0] mag[4];
      logic        neg[4];
      logic [15:0] v, o[4];
      limit_result_type res;
      p = cfg_power_limit;
      w = cfg_warn_buffer;
      r = (cfg_ref_power == 0) ? 1 : cfg_ref_power;
      total = 0;
      if (p == r) share = cfg_power_base;
      else begin
         d = (p > r) ? p - r : r - p;
         share = (cfg_power_base * fraction16(d, r)) >> 16;
      end
      if (energy < w) begin
         e = (energy > cfg_min_buffer) ? energy : cfg_min_buffer;
         lim = (cfg_buffer_limit * fraction16(e, w)) >> 16;
      end else if (power > (w << 6)) begin
         f = 0;
         if (power < (p << 6)) f = fraction16((p << 6) - power, p << 5);
         lim = cfg_buffer_limit + ((share * f) >> 16);
      end else lim = cfg_buffer_limit + share;
      if (lim > 131071) lim = 131071;
      for (int i = 0; i < 4; i++) begin
         v = cur[16*i +: 16];
         neg[i] = v[15];
         mag[i] = neg[i] ? 64'h10000 - v : v;
         total += mag[i];
         o[i] = v;
      end
      res.scaled = total > lim;
      if (res.scaled) begin
         q = fraction16(lim, total);
         for (int i = 0; i < 4; i++) begin
            a = (mag[i] * q) >> 16;
            o[i] = neg[i] ? 16'(64'h10000 - a) : 16'(a);
         end
      end
      res.c0 = o[0]; res.c1 = o[1]; res.c2 = o[2]; res.c3 = o[3];
      res.lim = lim[16:0];
      return res;
   endfunction

   // drop valid, then stay idle
   task automatic idle_burst();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [15:0] data);
      req_valid <= 1'b0;
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_POWER_LIMIT:  cfg_power_limit  = data[7:0];
         CSR_WARN_BUFFER:  cfg_warn_buffer  = data[7:0];
         CSR_MIN_BUFFER:   cfg_min_buffer   = data[7:0];
         CSR_BUFFER_LIMIT: cfg_buffer_limit = data;
         CSR_POWER_BASE:   cfg_power_base   = data;
         CSR_REF_POWER:    cfg_ref_power    = data[7:0];
         default: ;
      endcase
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // send one transaction; valid is held until accepted and dropped by the next idle
   task automatic send_item(logic [15:0] power, logic [8:0] energy,
                            logic [15:0] i0, i1, i2, i3);
      if (idle_enable && $urandom_range(0, 3) == 0) idle_burst();
      req_valid <= 1'b1;
      req_measured_power <= power;
      req_buffer_energy <= energy;
      req_motor_current_0 <= i0;
      req_motor_current_1 <= i1;
      req_motor_current_2 <= i2;
      req_motor_current_3 <= i3;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_results.push_back(predict_limit(power, energy, {i3, i2, i1, i0}));
   endtask

   function automatic logic [15:0] random_current();
      case ($urandom_range(0, 5))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'($urandom_range(0, 400)) - 16'd200;
         default: return 16'($urandom_range(0, 32768)) - 16'd16384;
      endcase
   endfunction

   task automatic send_random_item();
      logic [15:0] power;
      logic [8:0] energy;
      power = $urandom_range(0, 3) == 0 ? 16'($urandom) :
              16'($urandom_range(0, 2 * cfg_power_limit * 64 + 64));
      energy = 9'($urandom_range(0, 300));
      send_item(power, energy, random_current(), random_current(),
                random_current(), random_current());
   endtask

   // result side: random stalls if idle_enable; compare with the oldest expectation
   always @(posedge clock) begin
      limit_result_type exp_res, got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_limited_current_0, rsp_limited_current_1, rsp_limited_current_2,
                   rsp_limited_current_3, rsp_total_limit, rsp_was_scaled};
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, actual %h", $time, got);
               error_count++;
            end else begin
               exp_res = expected_results.pop_front();
               result_count++;
               if (exp_res.scaled) scaled_count++;
               if (got.c0 !== exp_res.c0 || got.c1 !== exp_res.c1 ||
                   got.c2 !== exp_res.c2 || got.c3 !== exp_res.c3 ||
                   got.lim !== exp_res.lim || got.scaled !== exp_res.scaled) begin
                  $display("%0t: mismatch, expected %h actual %h", $time, exp_res, got);
                  error_count++;
               end
            end
         end
         rsp_ready <= !idle_enable || ($urandom_range(0, 4) != 0);
      end
   end

   task automatic test_directed();
      send_item(16'd0, 9'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_item(16'hFFFF, 9'd300, 16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384);
      send_item(16'd3200, 9'd49, 16'sd100, -16'sd100, 16'sd5, 16'sd0);
      send_item(16'd3201, 9'd50, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
      send_item(16'd5119, 9'd255, -16'sd16384, 16'sd1, -16'sd1, 16'sd16384);
      send_item(16'd5120, 9'd256, 16'sh8000, 16'sd0, 16'sd0, 16'sd0);
      send_item(16'd4000, 9'd5, 16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0);
      send_item(16'd100, 9'd3, 16'sd10000, 16'sd10000, 16'sd10000, 16'sd10000);
      send_item(16'h5555, 9'h155, 16'sh5555, 16'shAAAA, 16'sh2AAA, -16'sd3);
      send_item(16'hAAAA, 9'h0AA, 16'shAAAA, 16'sh5555, 16'shD555, 16'sd3);
   endtask

   task automatic test_random_settings(int count);
      for (int n = 0; n < count; n++) send_random_item();
   endtask

   // sweep register extremes, including zero reference and zero threshold
   task automatic test_register_extremes();
      logic [7:0] pl[4] = '{8'd0, 8'd255, 8'd1, 8'd80};
      logic [7:0] wb[4] = '{8'd0, 8'd255, 8'd1, 8'd50};
      logic [7:0] mb[4] = '{8'd255, 8'd0, 8'd5, 8'd200};
      logic [15:0] bl[4] = '{16'hFFFF, 16'd0, 16'd16000, 16'd1};
      logic [15:0] pb[4] = '{16'hFFFF, 16'd0, 16'd20000, 16'd40000};
      logic [7:0] rp[4] = '{8'd0, 8'd255, 8'd1, 8'd80};
      for (int k = 0; k < 4; k++) begin
         drain_results();
         write_register(CSR_POWER_LIMIT, 16'(pl[k]));
         write_register(CSR_WARN_BUFFER, 16'(wb[k]));
         write_register(CSR_MIN_BUFFER, 16'(mb[k]));
         write_register(CSR_BUFFER_LIMIT, bl[k]);
         write_register(CSR_POWER_BASE, pb[k]);
         write_register(CSR_REF_POWER, 16'(rp[k]));
         send_item(16'd0, 9'd0, 16'sd16384, 16'sd16384, -16'sd16384, 16'sd1);
         send_item(16'hFFFF, 9'd300, 16'sd5, -16'sd5, 16'sd0, 16'sh8000);
         test_random_settings(60);
      end
   endtask

   task automatic test_random_registers();
      for (int k = 0; k < 5; k++) begin
         drain_results();
         write_register(CSR_POWER_LIMIT, 16'($urandom_range(0, 255)));
         write_register(CSR_WARN_BUFFER, 16'($urandom_range(1, 255)));
         write_register(CSR_MIN_BUFFER, 16'($urandom_range(0, 255)));
         write_register(CSR_BUFFER_LIMIT, 16'($urandom_range(0, 65535)));
         write_register(CSR_POWER_BASE, 16'($urandom_range(0, 65535)));
         write_register(CSR_REF_POWER, 16'($urandom_range(1, 255)));
         test_random_settings(100);
      end
   endtask

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      cfg_power_limit  = RST_POWER_LIMIT;
      cfg_warn_buffer  = RST_WARN_BUFFER;
      cfg_min_buffer   = RST_MIN_BUFFER;
      cfg_buffer_limit = RST_BUFFER_LIMIT;
      cfg_power_base   = RST_POWER_BASE;
      cfg_ref_power    = RST_REF_POWER;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_settings(150);
      // hold the sender until the pipeline empties
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      test_random_settings(50);
      test_register_extremes();
      test_random_registers();
      drain_results();
      write_register(CSR_POWER_LIMIT, 16'(RST_POWER_LIMIT));
      write_register(CSR_WARN_BUFFER, 16'(RST_WARN_BUFFER));
      write_register(CSR_MIN_BUFFER, 16'(RST_MIN_BUFFER));
      write_register(CSR_BUFFER_LIMIT, RST_BUFFER_LIMIT);
      write_register(CSR_POWER_BASE, RST_POWER_BASE);
      write_register(CSR_REF_POWER, 16'(RST_REF_POWER));
      idle_enable = 1'b0;
      test_random_settings(120);
      drain_results();
      $display("Checked %0d results (%0d scaled) across reset, extreme and random settings",
               result_count, scaled_count);
      if (error_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

[sim.f]
rtl/core/cpl_pkg.sv
rtl/core/cpl_div.sv
rtl/core/cpl_limit.sv
rtl/core/cpl_scale.sv
rtl/core/chassis_motor_current_power_limiter.sv
tb/sv/chassis_motor_current_power_limiter_tb.sv
